### rtl/assert_macros.svh
// assertion macros for the descriptor matcher
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/drmm_pkg.sv
// package for the descriptor matcher: constants, state type, function codes
// no dependencies
`timescale 1ns / 1ps
package drmm_pkg;
    localparam int MAX_DESC_DEF  = 512;
    localparam int DIM_DEF       = 256;
    localparam int ELEM_BITS_DEF = 8;
    localparam int DIST_W        = 25;
    localparam int CNT_W         = 10;
    localparam int RATIO_W       = 9;
    localparam int DIDX_W        = 9;
    localparam int EIDX_W        = 8;

    localparam logic [1:0] FUNC_LOAD_Q = 2'd0;
    localparam logic [1:0] FUNC_LOAD_T = 2'd1;
    localparam logic [1:0] FUNC_MATCH  = 2'd2;

    localparam logic [2:0] REG_QCOUNT = 3'd0;
    localparam logic [2:0] REG_TCOUNT = 3'd1;
    localparam logic [2:0] REG_THRESH = 3'd2;
    localparam logic [2:0] REG_RATIO  = 3'd3;
    localparam logic [2:0] REG_MUTUAL = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_RUN,
        ST_FWD_DRAIN,
        ST_FWD_PAIR,
        ST_TESTS,
        ST_CHK_RUN,
        ST_CHK_DRAIN,
        ST_CHK_PAIR,
        ST_RESULT
    } state_t;
endpackage

### rtl/drmm_ram.sv
// generic single-port synchronous ram, one write or read a cycle, registered read
// no dependencies
`timescale 1ns / 1ps
module drmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/descriptor_ratio_mutual_matcher.sv
// descriptor matcher top level: two descriptor rams, dot product sequencer, tests
// depends on drmm_pkg, drmm_ram and assert_macros.svh
//
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | func, desc_index, elem_index, elem_value
// out     | out_valid| out_stall | matched, query_index, train_index, best_distance
// cfg     | cfg_we   | -         | cfg_index, cfg_data
//
// a load writes one element; a match walks train_count pairs, each count capped at
// MAX_DESC, then with the cross check on and the forward tests passed query_count more
// pairs, one element product a cycle set by the single read port of each ram
// reset clears counts and control and sets the other config defaults; the rams are not cleared
// a waiting result holds in the output register; no new item is taken meanwhile
`timescale 1ns / 1ps
`include "assert_macros.svh"
module descriptor_ratio_mutual_matcher
    import drmm_pkg::*;
#(
    parameter int MAX_DESC  = MAX_DESC_DEF,
    parameter int DIM       = DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               func,
    input  logic [DIDX_W-1:0]        desc_index,
    input  logic [EIDX_W-1:0]        elem_index,
    input  logic signed [7:0]        elem_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     matched,
    output logic [DIDX_W-1:0]        query_index,
    output logic [DIDX_W-1:0]        train_index,
    output logic signed [DIST_W-1:0] best_distance,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [DIST_W-1:0]        cfg_data
);
    localparam int DW   = $clog2(MAX_DESC);
    localparam int KW   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW   = $clog2(MAX_DESC * DIM);
    localparam int NW   = DW + 1;
    localparam int PW   = 2 * ELEM_BITS;
    localparam int ACCW = PW + $clog2(DIM) + 3;
    localparam int WW   = ACCW + 10;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   qcount_reg;
    logic [CNT_W-1:0]   tcount_reg;
    logic [DIST_W-1:0]  thresh_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               mutual_reg;

    logic [DW-1:0]          qsel_reg, qsel_next;
    logic [DW-1:0]          tsel_reg, tsel_next;
    logic [NW-1:0]          iter_reg, iter_next;
    logic [KW:0]            kcnt_reg, kcnt_next;
    logic                   pv1_reg, pv1_next;
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic signed [WW-1:0]   best_reg, best_next;
    logic signed [WW-1:0]   second_reg, second_next;
    logic                   hb_reg, hb_next;
    logic                   hs_reg, hs_next;
    logic [DW-1:0]          bt_reg, bt_next;
    logic signed [WW-1:0]   cbest_reg, cbest_next;
    logic [DW-1:0]          cidx_reg, cidx_next;
    logic                   ok_reg, ok_next;
    logic [DIDX_W-1:0]      di_reg, di_next;

    logic                     ov_reg;
    logic                     om_reg;
    logic [DIDX_W-1:0]        oq_reg;
    logic [DIDX_W-1:0]        ot_reg;
    logic signed [DIST_W-1:0] od_reg;
    logic                     res_fire;

    logic [NW-1:0] nq, nt;
    logic          accept;
    logic          ld_ok;
    logic          qwe, twe;
    logic [AW-1:0] qaddr, taddr;
    logic [ELEM_BITS-1:0] qrd, trd, wd;
    logic [KW-1:0] kidx;
    logic signed [PW-1:0]   prod;
    logic signed [WW-1:0]   pdist;
    logic signed [WW-1:0]   thr;
    logic signed [WW+10:0]  lhs, rhs;

    assign nq = (qcount_reg > CNT_W'(MAX_DESC)) ? NW'(MAX_DESC) : NW'(qcount_reg);
    assign nt = (tcount_reg > CNT_W'(MAX_DESC)) ? NW'(MAX_DESC) : NW'(tcount_reg);

    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign accept   = in_valid && !in_stall;
    assign ld_ok    = ({23'd0, desc_index} < 32'(MAX_DESC)) && ({24'd0, elem_index} < 32'(DIM));
    assign wd       = ELEM_BITS'(elem_value);
    assign kidx     = kcnt_reg[KW-1:0];

    always_comb
    begin
        qwe   = accept && (func == FUNC_LOAD_Q) && ld_ok;
        twe   = accept && (func == FUNC_LOAD_T) && ld_ok;
        qaddr = AW'(qsel_reg) * AW'(DIM) + AW'(kidx);
        taddr = AW'(tsel_reg) * AW'(DIM) + AW'(kidx);
        if (state_reg == ST_IDLE)
        begin
            qaddr = AW'(desc_index[DW-1:0]) * AW'(DIM) + AW'(elem_index);
            taddr = qaddr;
        end
    end

    drmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DESC * DIM)) u_qram (
        .clk(clk), .we(qwe), .addr(qaddr), .wdata(wd), .rdata(qrd)
    );
    drmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(MAX_DESC * DIM)) u_tram (
        .clk(clk), .we(twe), .addr(taddr), .wdata(wd), .rdata(trd)
    );

    assign prod  = $signed(qrd) * $signed(trd);
    assign pdist = (WW'(1) <<< (2 * (ELEM_BITS - 1) + 1)) - (WW'(acc_reg) <<< 1);
    assign thr   = WW'($signed(thresh_reg));
    assign lhs   = (WW + 11)'(best_reg) <<< 8;
    assign rhs   = $signed({1'b0, ratio_reg}) * (WW + 11)'(second_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_MATCH)
                begin
                    if ({23'd0, desc_index} < 32'(nq) && nt != '0)
                        state_next = ST_FWD_RUN;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_FWD_RUN:   if (kcnt_reg == (KW + 1)'(DIM - 1)) state_next = ST_FWD_DRAIN;
            ST_FWD_DRAIN: state_next = ST_FWD_PAIR;
            ST_FWD_PAIR:  state_next = (iter_reg == nt - NW'(1)) ? ST_TESTS : ST_FWD_RUN;
            ST_TESTS:
            begin
                if (ok_next && mutual_reg)
                    state_next = ST_CHK_RUN;
                else
                    state_next = ST_RESULT;
            end
            ST_CHK_RUN:   if (kcnt_reg == (KW + 1)'(DIM - 1)) state_next = ST_CHK_DRAIN;
            ST_CHK_DRAIN: state_next = ST_CHK_PAIR;
            ST_CHK_PAIR:  state_next = (iter_reg == nq - NW'(1)) ? ST_RESULT : ST_CHK_RUN;
            ST_RESULT:    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        qsel_next   = qsel_reg;
        tsel_next   = tsel_reg;
        iter_next   = iter_reg;
        kcnt_next   = kcnt_reg;
        pv1_next    = 1'b0;
        acc_next    = acc_reg;
        best_next   = best_reg;
        second_next = second_reg;
        hb_next     = hb_reg;
        hs_next     = hs_reg;
        bt_next     = bt_reg;
        cbest_next  = cbest_reg;
        cidx_next   = cidx_reg;
        ok_next     = ok_reg;
        di_next     = di_reg;
        if (pv1_reg)
            acc_next = acc_reg + ACCW'(prod);
        case (state_reg)
            ST_IDLE:
            begin
                di_next   = desc_index;
                qsel_next = desc_index[DW-1:0];
                tsel_next = '0;
                iter_next = '0;
                kcnt_next = '0;
                acc_next  = '0;
                hb_next   = 1'b0;
                hs_next   = 1'b0;
                ok_next   = 1'b0;
                bt_next   = '0;
                best_next = '0;
            end
            ST_FWD_RUN, ST_CHK_RUN:
            begin
                pv1_next  = 1'b1;
                kcnt_next = kcnt_reg + (KW + 1)'(1);
            end
            ST_FWD_PAIR:
            begin
                if (!hb_reg || pdist < best_reg)
                begin
                    if (hb_reg)
                    begin
                        second_next = best_reg;
                        hs_next     = 1'b1;
                    end
                    best_next = pdist;
                    bt_next   = iter_reg[DW-1:0];
                    hb_next   = 1'b1;
                end
                else if (!hs_reg || pdist < second_reg)
                begin
                    second_next = pdist;
                    hs_next     = 1'b1;
                end
                iter_next = iter_reg + NW'(1);
                tsel_next = tsel_reg + DW'(1);
                kcnt_next = '0;
                acc_next  = '0;
            end
            ST_TESTS:
            begin
                ok_next = (best_reg < thr) && (!hs_reg || lhs < rhs);
                iter_next = '0;
                qsel_next = '0;
                tsel_next = bt_reg;
                kcnt_next = '0;
                acc_next  = '0;
            end
            ST_CHK_PAIR:
            begin
                if (iter_reg == '0 || pdist < cbest_reg)
                begin
                    cbest_next = pdist;
                    cidx_next  = iter_reg[DW-1:0];
                end
                iter_next = iter_reg + NW'(1);
                qsel_next = qsel_reg + DW'(1);
                kcnt_next = '0;
                acc_next  = '0;
            end
            ST_RESULT:
            begin
                if (mutual_reg && ok_reg)
                    ok_next = (DIDX_W'(cidx_reg) == di_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign res_fire = (state_reg == ST_RESULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            qcount_reg <= '0;
            tcount_reg <= '0;
            thresh_reg <= DIST_W'(16384);
            ratio_reg  <= RATIO_W'(256);
            mutual_reg <= 1'b1;
            ov_reg     <= 1'b0;
            pv1_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv1_reg   <= pv1_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QCOUNT: qcount_reg <= cfg_data[CNT_W-1:0];
                    REG_TCOUNT: tcount_reg <= cfg_data[CNT_W-1:0];
                    REG_THRESH: thresh_reg <= cfg_data;
                    REG_RATIO:  ratio_reg  <= cfg_data[RATIO_W-1:0];
                    REG_MUTUAL: mutual_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (res_fire)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        qsel_reg   <= qsel_next;
        tsel_reg   <= tsel_next;
        iter_reg   <= iter_next;
        kcnt_reg   <= kcnt_next;
        acc_reg    <= acc_next;
        best_reg   <= best_next;
        second_reg <= second_next;
        hb_reg     <= hb_next;
        hs_reg     <= hs_next;
        bt_reg     <= bt_next;
        cbest_reg  <= cbest_next;
        cidx_reg   <= cidx_next;
        ok_reg     <= ok_next;
        di_reg     <= di_next;
        if (res_fire)
        begin
            om_reg <= ok_next;
            oq_reg <= di_reg;
            ot_reg <= hb_reg ? DIDX_W'(bt_reg) : '0;
            od_reg <= hb_reg ? best_reg[DIST_W-1:0] : '0;
        end
    end

    assign out_valid     = ov_reg;
    assign matched       = om_reg;
    assign query_index   = oq_reg;
    assign train_index   = ot_reg;
    assign best_distance = od_reg;

    `ASSERT_IMPLIES(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_NEXT(a_result_out, clk, rst_n, res_fire, out_valid)
    `ASSERT_IMPLIES(a_no_result_pending, clk, rst_n, res_fire, !ov_reg)
endmodule

### tb/sv/descriptor_ratio_mutual_matcher_test.sv
// testbench for descriptor_ratio_mutual_matcher: queued driver, clocked monitor,
// in-bench distance predictor with ratio and cross checks; depends on drmm_pkg
`timescale 1ns / 1ps
module descriptor_ratio_mutual_matcher_test;
    import drmm_pkg::*;

    localparam int N_DESC     = 512;
    localparam int N_DIM      = 256;
    localparam int ONE_Q      = 16384;
    localparam int WATCH_MAX  = 60000;
    localparam int HOLD_CYCLES = 2500;
    localparam int SETTLE_CYCLES = 30;
    localparam int FUNC_NONE  = 3;

    typedef struct packed {
        logic [1:0]        func;
        logic [DIDX_W-1:0] desc_index;
        logic [EIDX_W-1:0] elem_index;
        logic signed [7:0] elem_value;
    } item_t;

    typedef struct packed {
        logic                     matched;
        logic [DIDX_W-1:0]        query_index;
        logic [DIDX_W-1:0]        train_index;
        logic signed [DIST_W-1:0] best_distance;
    } match_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [DIDX_W-1:0] desc_index = '0;
    logic [EIDX_W-1:0] elem_index = '0;
    logic signed [7:0] elem_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic matched;
    logic [DIDX_W-1:0] query_index;
    logic [DIDX_W-1:0] train_index;
    logic signed [DIST_W-1:0] best_distance;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [DIST_W-1:0] cfg_data = '0;

    descriptor_ratio_mutual_matcher uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .desc_index(desc_index), .elem_index(elem_index),
        .elem_value(elem_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .matched(matched), .query_index(query_index), .train_index(train_index),
        .best_distance(best_distance),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    item_t pending_items[$];
    match_t expected_matches[$];

    logic signed [7:0] query_mem [0:N_DESC-1][0:N_DIM-1];
    logic signed [7:0] train_mem [0:N_DESC-1][0:N_DIM-1];
    int q_plan [0:7][0:N_DIM-1];

    logic [CNT_W-1:0]  query_count = 10'd0;
    logic [CNT_W-1:0]  train_count = 10'd0;
    logic [DIST_W-1:0] dist_threshold = 25'd16384;
    logic [RATIO_W-1:0] ratio_q8 = 9'd256;
    logic mutual_check = 1'b1;

    int errors = 0;
    int cycle_cnt = 0;
    int idle_cnt = 0;
    int n_loads = 0;
    int n_matches = 0;
    int n_hits = 0;
    int hold_cnt = 0;
    bit hold_arm = 1'b0;
    bit in_took = 1'b0;
    bit out_took = 1'b0;

    function automatic bit calm();
        return (cycle_cnt % 100000) < 15000;
    endfunction

    function automatic int pair_distance(int qi, int ti);
        int dot;
        dot = 0;
        for (int k = 0; k < N_DIM; k++)
            dot += int'(query_mem[qi][k]) * int'(train_mem[ti][k]);
        return 2 * (ONE_Q - dot);
    endfunction

    task automatic predict_match(input int qi);
        match_t r;
        int nq, nt, best, second, best_t, d, cbest, cidx;
        bit have_best, have_second, ok;
        longint thr;
        nq = (query_count > N_DESC) ? N_DESC : query_count;
        nt = (train_count > N_DESC) ? N_DESC : train_count;
        have_best = 0;
        have_second = 0;
        best = 0;
        second = 0;
        best_t = 0;
        ok = 0;
        if (qi < nq)
        begin
            for (int t = 0; t < nt; t++)
            begin
                d = pair_distance(qi, t);
                if (!have_best || d < best)
                begin
                    if (have_best)
                    begin
                        second = best;
                        have_second = 1;
                    end
                    best = d;
                    best_t = t;
                    have_best = 1;
                end
                else if (!have_second || d < second)
                begin
                    second = d;
                    have_second = 1;
                end
            end
        end
        if (have_best)
        begin
            thr = longint'($signed(dist_threshold));
            ok = best < thr;
            if (ok && have_second)
                ok = longint'(best) * 256 < longint'(ratio_q8) * longint'(second);
            if (ok && mutual_check)
            begin
                cbest = 0;
                cidx = 0;
                for (int q = 0; q < nq; q++)
                begin
                    d = pair_distance(q, best_t);
                    if (q == 0 || d < cbest)
                    begin
                        cbest = d;
                        cidx = q;
                    end
                end
                ok = (cidx == qi);
            end
        end
        r.matched = ok;
        r.query_index = qi[DIDX_W-1:0];
        r.train_index = have_best ? best_t[DIDX_W-1:0] : '0;
        r.best_distance = have_best ? best[DIST_W-1:0] : '0;
        expected_matches.insert(expected_matches.size(), r);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // monitor: input transfers feed the predictor, output transfers are checked
    always @(posedge clk)
    begin
        match_t w;
        cycle_cnt++;
        in_took = rst_n && in_valid && !in_stall;
        out_took = rst_n && out_valid && !out_stall;
        if (in_took)
        begin
            if (func == FUNC_LOAD_Q)
            begin
                query_mem[desc_index][elem_index] = elem_value;
                n_loads++;
            end
            else if (func == FUNC_LOAD_T)
            begin
                train_mem[desc_index][elem_index] = elem_value;
                n_loads++;
            end
            else if (func == FUNC_MATCH)
                predict_match(desc_index);
        end
        if (out_took)
        begin
            if (expected_matches.size() == 0)
                report("unexpected result transfer, query_index", query_index, 0);
            else
            begin
                w = expected_matches.pop_front();
                n_matches++;
                if (w.matched)
                    n_hits++;
                if (matched !== w.matched)
                    report("matched", matched, w.matched);
                if (query_index !== w.query_index)
                    report("query_index", query_index, w.query_index);
                if (train_index !== w.train_index)
                    report("train_index", train_index, w.train_index);
                if (best_distance !== w.best_distance)
                    report("best_distance", best_distance, w.best_distance);
            end
        end
        if (in_took || out_took)
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt > WATCH_MAX)
        begin
            $display("descriptor_ratio_mutual_matcher_test NOT OK");
            $finish;
        end
    end

    // driver for the input channel
    always @(negedge clk)
    begin
        item_t it;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (pending_items.size() > 0 && (calm() || $urandom_range(99) >= 9))
            begin
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                func <= it.func;
                desc_index <= it.desc_index;
                elem_index <= it.elem_index;
                elem_value <= it.elem_value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall, with one long hold-off once armed
    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_arm && out_valid)
        begin
            out_stall <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
            hold_arm <= 1'b0;
        end
        else
            out_stall <= !calm() && ($urandom_range(99) < 9);
    end

    task automatic push_item(input int f, input int d, input int e, input int v);
        item_t it;
        it.func = f[1:0];
        it.desc_index = d[DIDX_W-1:0];
        it.elem_index = e[EIDX_W-1:0];
        it.elem_value = v[7:0];
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic settle();
        while (pending_items.size() > 0 || in_valid || expected_matches.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[DIST_W-1:0];
        case (idx)
            REG_QCOUNT: query_count = val[CNT_W-1:0];
            REG_TCOUNT: train_count = val[CNT_W-1:0];
            REG_THRESH: dist_threshold = val[DIST_W-1:0];
            REG_RATIO:  ratio_q8 = val[RATIO_W-1:0];
            REG_MUTUAL: mutual_check = val[0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(input int qc, input int tc, input int thr, input int ratio,
                         input int mut);
        settle();
        write_reg(REG_QCOUNT, qc);
        write_reg(REG_TCOUNT, tc);
        write_reg(REG_THRESH, thr);
        write_reg(REG_RATIO, ratio);
        write_reg(REG_MUTUAL, mut);
    endtask

    function automatic int pick_desc();
        int r;
        r = $urandom_range(8);
        return (r == 8) ? N_DESC - 1 : r;
    endfunction

    initial
    begin
        int v, qc, tc, thr, r, d;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // counts still zero after reset, plus an unused function code
        push_item(FUNC_MATCH, 0, 0, 0);
        push_item(FUNC_NONE, 511, 255, -1);
        push_item(FUNC_MATCH, 511, 0, 0);

        for (int q = 0; q < 8; q++)
            for (int k = 0; k < N_DIM; k++)
            begin
                if (q == 0)
                    v = -128;
                else if (q == 1)
                    v = 127;
                else
                    v = $urandom_range(255) - 128;
                q_plan[q][k] = v;
                push_item(FUNC_LOAD_Q, q, k, v);
            end
        for (int t = 0; t < 8; t++)
            for (int k = 0; k < N_DIM; k++)
            begin
                if (t == 0)
                    v = -128;
                else if (t == 1 || t == 2)
                    v = 127;
                else
                begin
                    v = q_plan[t][k] + $urandom_range(40) - 20;
                    v = (v > 127) ? 127 : ((v < -128) ? -128 : v);
                end
                push_item(FUNC_LOAD_T, t, k, v);
            end
        for (int k = 0; k < N_DIM; k++)
        begin
            push_item(FUNC_LOAD_Q, N_DESC - 1, k, $urandom_range(255) - 128);
            push_item(FUNC_LOAD_T, N_DESC - 1, k, $urandom_range(255) - 128);
        end

        setup(4, 4, 16384, 256, 1);
        for (int q = 0; q < 4; q++)
            push_item(FUNC_MATCH, q, 0, 0);
        push_item(FUNC_MATCH, 5, 0, 0);

        // single train descriptor, so no second candidate
        setup(3, 1, 8421376, 0, 0);
        for (int q = 0; q < 3; q++)
            push_item(FUNC_MATCH, q, 0, 0);

        // count above the store size saturates; cross check stays off
        setup(1023, 8, -8388608, 256, 0);
        push_item(FUNC_MATCH, N_DESC - 1, 0, 0);
        push_item(FUNC_MATCH, 0, 0, 0);
        setup(512, 3, 8421376, 128, 0);
        push_item(FUNC_MATCH, N_DESC - 1, 0, 0);
        push_item(FUNC_MATCH, 1, 0, 0);

        setup(8, 8, 8421376, 256, 1);
        for (int q = 0; q < 8; q++)
            push_item(FUNC_MATCH, q, 0, 0);

        for (int p = 0; p < 7; p++)
        begin
            qc = $urandom_range(1, 8);
            tc = $urandom_range(0, 8);
            r = $urandom_range(3);
            if (r == 0)
                thr = -8388608;
            else if (r == 1)
                thr = 8421376;
            else
                thr = $urandom_range(400000) - 200000;
            setup(qc, tc, thr, $urandom_range(256), $urandom_range(1));
            if (p == 2)
                hold_arm = 1'b1;
            for (int i = 0; i < 16; i++)
            begin
                r = $urandom_range(99);
                if (r < 65)
                    push_item(FUNC_MATCH, $urandom_range(qc - 1), $urandom, $urandom);
                else if (r < 72)
                    push_item(FUNC_MATCH, $urandom_range(511), $urandom, $urandom);
                else if (r < 95)
                begin
                    d = pick_desc();
                    push_item(($urandom_range(1) == 0) ? FUNC_LOAD_Q : FUNC_LOAD_T, d,
                              $urandom_range(255), $urandom_range(255) - 128);
                end
                else
                    push_item(FUNC_NONE, $urandom, $urandom, $urandom);
            end
        end

        settle();
        $display("checked %0d match results (%0d matched) after %0d element loads",
                 n_matches, n_hits, n_loads);
        $display("settings swept counts, threshold and ratio extremes, cross check on and off");
        if (errors == 0)
            $display("descriptor_ratio_mutual_matcher_test OK");
        else
            $display("descriptor_ratio_mutual_matcher_test NOT OK");
        $finish;
    end
endmodule
